// ----- rtl/core/vsbg_pkg.sv -----
`timescale 1ns / 1ps

package vsbg_pkg;

   localparam int ADDR_W   = 23;
   localparam int REG_W    = 32;
   localparam int FIELD_W  = 12;
   localparam int SPAN_W   = 10;
   localparam int STAMP_W  = 32;
   localparam int SIZE_W   = 2;

   localparam int REGISTRY_DEPTH_DEFAULT = 16;

   // Bit positions inside the video-interface registers.
   localparam int SERRATE_BIT = 6;
   localparam int START_LSB   = 16;

   // Item commands.
   localparam logic CMD_NOTE  = 1'b0;
   localparam logic CMD_FRAME = 1'b1;

   // Pixel types and the pixel size codes they map to.
   localparam logic [1:0] PIX_TYPE_16 = 2'd2;
   localparam logic [1:0] PIX_TYPE_32 = 2'd3;
   localparam logic [SIZE_W-1:0] SIZE_16 = 2'd2;
   localparam logic [SIZE_W-1:0] SIZE_32 = 2'd3;

   localparam logic [FIELD_W-1:0] BLANK_WIDTH  = 12'd320;
   localparam logic [FIELD_W-1:0] BLANK_HEIGHT = 12'd240;
   localparam int                 MAX_HEIGHT   = 720;

   // Width estimate compares span * scale * 15 against stride * 8192.
   localparam logic [FIELD_W-1:0] WIDTH_RATIO_NUM = 12'd15;
   localparam int                 WIDTH_RATIO_SHIFT = 13;

   // Height quotient width and the number of divider steps.
   localparam int QUOT_W    = 24;
   localparam int DIV_STEPS = QUOT_W;

   typedef struct packed {
      logic                command;
      logic [ADDR_W-1:0]   buffer_address;
      logic [REG_W-1:0]    vi_status;
      logic [ADDR_W-1:0]   vi_origin;
      logic [FIELD_W-1:0]  line_stride;
      logic [REG_W-1:0]    vi_h_start;
      logic [FIELD_W-1:0]  vi_x_scale;
      logic [REG_W-1:0]    vi_v_start;
      logic [FIELD_W-1:0]  vi_y_scale;
      logic                odd_line;
      logic                game_started;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   frame_address;
      logic [FIELD_W-1:0]  frame_width;
      logic [FIELD_W-1:0]  frame_height;
      logic [SIZE_W-1:0]   pixel_size;
      logic                blank;
      logic                changed;
   } rsp_type;

endpackage

// ----- rtl/core/video_scanout_buffer_gate_core.sv -----
`timescale 1ns / 1ps

// Scanout buffer gate. Once per video field the host sends a frame item holding the
// video-interface register values; between fields it sends note items that record
// which framebuffer bases have been rendered. A note item gives no result. A frame
// item gives one result item: scanout address, width, height, pixel size, a blank
// flag and a changed flag against the previous frame.
// Both channels use valid/stall; an item moves when valid is high and stall is low.
// The block works on one item at a time and stalls the request side until it is done.
// A frame item runs the height division only when the vertical window is open and the
// vertical scale and width are nonzero, then scans the registry until a match or the
// end of the entries; a raw blank frame reads no entries. One shared 22x12 multiplier
// is used five times, the height quotient comes from a 24-step restoring divider, and
// the scan reads each entry in a read state and a compare state from a memory with one
// registered read port. A note item searches the registry entries for its base. The
// result sits in an output register, so a new item is accepted while a result waits on
// a stalled receiver; a later frame then holds in its last step until the register
// frees. Reset empties the registry, clears the blank generation and the
// previous-frame record, and marks the next frame as changed.
module video_scanout_buffer_gate_core #(
   parameter int REGISTRY_DEPTH = vsbg_pkg::REGISTRY_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vsbg_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vsbg_pkg::rsp_type rsp_payload
);

   localparam int IDX_W = (REGISTRY_DEPTH > 1) ? $clog2(REGISTRY_DEPTH) : 1;
   localparam int CNT_W = $clog2(REGISTRY_DEPTH + 1);

   localparam int ADDR_W  = vsbg_pkg::ADDR_W;
   localparam int FIELD_W = vsbg_pkg::FIELD_W;
   localparam int SPAN_W  = vsbg_pkg::SPAN_W;
   localparam int STAMP_W = vsbg_pkg::STAMP_W;
   localparam int QUOT_W  = vsbg_pkg::QUOT_W;
   localparam int MUL_A_W = SPAN_W + FIELD_W;
   localparam int PROD_W  = MUL_A_W + FIELD_W;
   localparam int ROW_W   = FIELD_W + 3;
   localparam int SUM_W   = PROD_W + 2;
   localparam int LIM_W   = 2 * FIELD_W + 3;
   localparam int DCNT_W  = $clog2(vsbg_pkg::DIV_STEPS + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_HMUL,
      S_HSCALE,
      S_WIDTH,
      S_ROW,
      S_DIVINIT,
      S_DIV,
      S_HFIN,
      S_SPAN,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DONE,
      S_NOTE_RD,
      S_NOTE_CMP
   } state_type;

   // Registry storage: one write port, one registered read port.
   logic [ADDR_W-1:0]  registry_base_mem  [REGISTRY_DEPTH];
   logic [STAMP_W-1:0] registry_stamp_mem [REGISTRY_DEPTH];
   logic [ADDR_W-1:0]  rd_base_ff;
   logic [STAMP_W-1:0] rd_stamp_ff;
   logic               base_we;
   logic               stamp_we;
   logic [IDX_W-1:0]   mem_waddr;

   state_type             state_ff, state_in;
   vsbg_pkg::req_type     item_ff, item_in;
   vsbg_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]    w_ff, w_in;
   logic [FIELD_W-1:0]    h_ff, h_in;
   logic [ADDR_W-1:0]     fb_ff, fb_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [QUOT_W-1:0]     q_ff, q_in;
   logic [FIELD_W-1:0]    rem_ff, rem_in;
   logic [DCNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic                  hgo_ff, hgo_in;
   logic                  rendered_ff, rendered_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [STAMP_W-1:0]    gen_ff, gen_in;
   logic                  prev_blank_ff, prev_blank_in;
   logic [ADDR_W-1:0]     last_addr_ff, last_addr_in;
   logic [31:0]           last_status_ff, last_status_in;
   logic [FIELD_W-1:0]    last_width_ff, last_width_in;
   logic                  last_blank_ff, last_blank_in;
   logic                  first_frame_ff, first_frame_in;

   // Field decode of the captured item.
   logic [1:0]          pix_type;
   logic                serrate;
   logic                blank_raw;
   logic [SPAN_W-1:0]   h_first;
   logic [SPAN_W-1:0]   h_last;
   logic [SPAN_W-1:0]   v_first;
   logic [SPAN_W-1:0]   v_last;
   logic [1:0]          bpp_shift;
   logic [1:0]          row_shift;
   logic [ROW_W-1:0]    row_offset;
   logic [FIELD_W+1:0]  w_times3;

   // Shared multiplier.
   logic [MUL_A_W-1:0]  mul_a;
   logic [FIELD_W-1:0]  mul_b;
   logic [PROD_W-1:0]   mul_prod;

   // Divider step, height rounding and registry compare.
   logic [SUM_W-1:0]    div_sum;
   logic [FIELD_W:0]    div_trial;
   logic                div_ge;
   logic [QUOT_W:0]     h_round;
   logic                halve;
   logic [LIM_W-1:0]    span_bytes;
   logic [LIM_W-1:0]    base_limit;
   logic                hit;
   logic                blank_final;
   logic                out_free;
   logic                changed;

   assign pix_type  = item_ff.vi_status[1:0];
   assign serrate   = item_ff.vi_status[vsbg_pkg::SERRATE_BIT];
   assign blank_raw = (pix_type != vsbg_pkg::PIX_TYPE_16 && pix_type != vsbg_pkg::PIX_TYPE_32)
                      || (item_ff.line_stride == '0) || (item_ff.vi_h_start == '0)
                      || !item_ff.game_started;
   assign h_first   = item_ff.vi_h_start[vsbg_pkg::START_LSB +: SPAN_W];
   assign h_last    = item_ff.vi_h_start[SPAN_W-1:0];
   assign v_first   = item_ff.vi_v_start[vsbg_pkg::START_LSB +: SPAN_W];
   assign v_last    = item_ff.vi_v_start[SPAN_W-1:0];

   // 16-bit pixels are two bytes, 32-bit pixels four; an odd serrated field skips
   // an extra row.
   assign bpp_shift  = (pix_type == vsbg_pkg::PIX_TYPE_32) ? 2'd2 : 2'd1;
   assign row_shift  = bpp_shift + ((serrate && item_ff.odd_line) ? 2'd1 : 2'd0);
   assign row_offset = ROW_W'(w_ff) << row_shift;
   assign w_times3   = {1'b0, w_ff, 1'b0} + (FIELD_W+2)'(w_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_HMUL: begin
            mul_a = MUL_A_W'(h_last - h_first);
            mul_b = item_ff.vi_x_scale;
         end
         S_HSCALE: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = vsbg_pkg::WIDTH_RATIO_NUM;
         end
         S_WIDTH: begin
            mul_a = MUL_A_W'(v_last - v_first);
            mul_b = item_ff.vi_y_scale;
         end
         S_ROW: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = item_ff.line_stride;
         end
         S_SPAN: begin
            mul_a = MUL_A_W'(h_ff);
            mul_b = w_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   // The width is halved when the estimated display width falls below the
   // stride divided by 1.875, done as an exact cross-multiplied compare.
   assign halve = serrate && !blank_raw && (item_ff.vi_x_scale != '0) && (h_last >= h_first)
                  && ({1'b0, prod_ff} < (PROD_W+1)'({item_ff.line_stride,
                                                    {vsbg_pkg::WIDTH_RATIO_SHIFT{1'b0}}}));

   // Round-half-up quotient of num / (2048 * w) equals
   // floor(floor((2*num + 2048*w) / 4096) / w).
   assign div_sum   = SUM_W'({prod_ff, 1'b0}) + SUM_W'({w_ff, 11'b0});
   assign div_ge    = {rem_ff, q_ff[QUOT_W-1]} >= {1'b0, w_ff};
   assign div_trial = {rem_ff, q_ff[QUOT_W-1]} - {1'b0, w_ff};

   // Adding two and rounding to a multiple of four collapses to (q + 4) & ~3.
   assign h_round = (QUOT_W+1)'(q_ff) + (QUOT_W+1)'(4);

   assign span_bytes = (pix_type == vsbg_pkg::PIX_TYPE_32) ?
                       LIM_W'({prod_ff[2*FIELD_W-1:0], 2'b00}) :
                       LIM_W'({prod_ff[2*FIELD_W-1:0], 1'b0});
   assign base_limit = LIM_W'(rd_base_ff) + span_bytes;
   assign hit = (fb_ff >= rd_base_ff) && (LIM_W'(fb_ff) < base_limit) && (rd_stamp_ff == gen_ff);

   assign blank_final = blank_raw || !rendered_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign changed     = first_frame_ff || (fb_ff != last_addr_ff)
                        || (item_ff.vi_status != last_status_ff)
                        || (item_ff.line_stride != last_width_ff)
                        || (blank_final != last_blank_ff);

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      w_in           = w_ff;
      h_in           = h_ff;
      fb_in          = fb_ff;
      prod_in        = prod_ff;
      q_in           = q_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      hgo_in         = hgo_ff;
      rendered_in    = rendered_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      gen_in         = gen_ff;
      prev_blank_in  = prev_blank_ff;
      last_addr_in   = last_addr_ff;
      last_status_in = last_status_ff;
      last_width_in  = last_width_ff;
      last_blank_in  = last_blank_ff;
      first_frame_in = first_frame_ff;
      base_we        = 1'b0;
      stamp_we       = 1'b0;
      mem_waddr      = idx_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_payload;
               idx_in  = '0;
               if (req_payload.command == vsbg_pkg::CMD_FRAME) begin
                  state_in = S_HMUL;
               end else if (req_payload.buffer_address != '0) begin
                  state_in = S_NOTE_RD;
               end
            end
         end
         S_HMUL: begin
            prod_in  = mul_prod;
            state_in = S_HSCALE;
         end
         S_HSCALE: begin
            prod_in  = mul_prod;
            state_in = S_WIDTH;
         end
         S_WIDTH: begin
            w_in     = halve ? {1'b0, item_ff.line_stride[FIELD_W-1:1]} : item_ff.line_stride;
            prod_in  = mul_prod;
            state_in = S_ROW;
         end
         S_ROW: begin
            // The origin backs up by one row (two on an odd serrated field) unless that would pass address zero.
            fb_in    = (ADDR_W'(row_offset) <= item_ff.vi_origin) ?
                       item_ff.vi_origin - ADDR_W'(row_offset) : item_ff.vi_origin;
            h_in     = w_times3[FIELD_W+1:2];
            hgo_in   = (v_last > v_first) && (item_ff.vi_y_scale != '0) && (w_ff != '0);
            prod_in  = mul_prod;
            state_in = S_DIVINIT;
         end
         S_DIVINIT: begin
            q_in       = div_sum[SUM_W-1 -: QUOT_W];
            rem_in     = '0;
            div_cnt_in = DCNT_W'(vsbg_pkg::DIV_STEPS);
            state_in   = hgo_ff ? S_DIV : S_HFIN;
         end
         S_DIV: begin
            rem_in     = div_ge ? div_trial[FIELD_W-1:0] : {rem_ff[FIELD_W-2:0], q_ff[QUOT_W-1]};
            q_in       = {q_ff[QUOT_W-2:0], div_ge};
            div_cnt_in = div_cnt_ff - DCNT_W'(1);
            if (div_cnt_ff == DCNT_W'(1)) begin
               state_in = S_HFIN;
            end
         end
         S_HFIN: begin
            if (hgo_ff && ({h_round[QUOT_W:2], 2'b00} <= (QUOT_W+1)'(vsbg_pkg::MAX_HEIGHT))) begin
               h_in = {h_round[FIELD_W-1:2], 2'b00};
            end
            // A new blank period opens a new generation of rendered buffers.
            if (blank_raw && !prev_blank_ff) begin
               gen_in = gen_ff + STAMP_W'(1);
            end
            prev_blank_in = blank_raw;
            state_in      = S_SPAN;
         end
         S_SPAN: begin
            prod_in     = mul_prod;
            idx_in      = '0;
            rendered_in = 1'b0;
            state_in    = blank_raw ? S_DONE : S_SCAN_RD;
         end
         S_SCAN_RD: begin
            state_in = (idx_ff == count_ff) ? S_DONE : S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (hit) begin
               rendered_in = 1'b1;
               state_in    = S_DONE;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in.frame_address = fb_ff;
               rsp_in.frame_width   = blank_final ? vsbg_pkg::BLANK_WIDTH : w_ff;
               rsp_in.frame_height  = blank_final ? vsbg_pkg::BLANK_HEIGHT : h_ff;
               rsp_in.pixel_size    = (pix_type == vsbg_pkg::PIX_TYPE_32) ?
                                      vsbg_pkg::SIZE_32 : vsbg_pkg::SIZE_16;
               rsp_in.blank         = blank_final;
               rsp_in.changed       = changed;
               rsp_valid_in         = 1'b1;
               first_frame_in       = 1'b0;
               last_addr_in         = fb_ff;
               last_status_in       = item_ff.vi_status;
               last_width_in        = item_ff.line_stride;
               last_blank_in        = blank_final;
               state_in             = S_IDLE;
            end
         end
         S_NOTE_RD: begin
            if (idx_ff == count_ff) begin
               // Not present: append while there is room.
               if (count_ff < CNT_W'(REGISTRY_DEPTH)) begin
                  base_we   = 1'b1;
                  stamp_we  = 1'b1;
                  mem_waddr = count_ff[IDX_W-1:0];
                  count_in  = count_ff + CNT_W'(1);
               end
               state_in = S_IDLE;
            end else begin
               state_in = S_NOTE_CMP;
            end
         end
         S_NOTE_CMP: begin
            if (rd_base_ff == item_ff.buffer_address) begin
               stamp_we = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_NOTE_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (base_we) begin
         registry_base_mem[mem_waddr] <= item_ff.buffer_address;
      end
      if (stamp_we) begin
         registry_stamp_mem[mem_waddr] <= gen_ff;
      end
      rd_base_ff  <= registry_base_mem[idx_ff[IDX_W-1:0]];
      rd_stamp_ff <= registry_stamp_mem[idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      rsp_ff     <= rsp_in;
      w_ff       <= w_in;
      h_ff       <= h_in;
      fb_ff      <= fb_in;
      prod_ff    <= prod_in;
      q_ff       <= q_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      hgo_ff     <= hgo_in;
      rendered_ff <= rendered_in;
      idx_ff     <= idx_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         count_ff       <= '0;
         gen_ff         <= '0;
         prev_blank_ff  <= 1'b0;
         last_addr_ff   <= '0;
         last_status_ff <= '0;
         last_width_ff  <= '0;
         last_blank_ff  <= 1'b1;
         first_frame_ff <= 1'b1;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         count_ff       <= count_in;
         gen_ff         <= gen_in;
         prev_blank_ff  <= prev_blank_in;
         last_addr_ff   <= last_addr_in;
         last_status_ff <= last_status_in;
         last_width_ff  <= last_width_in;
         last_blank_ff  <= last_blank_in;
         first_frame_ff <= first_frame_in;
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the scanout buffer gate. Note items and frame items
// go in through a bursty sender, and results come back through a receiver
// that stalls in changing styles. A predictor in this module keeps its own
// registry of rendered bases and its own previous-frame record, so every
// frame item can be checked field by field.
module tb_top;
   import vsbg_pkg::*;

   localparam int SLOTS        = REGISTRY_DEPTH_DEFAULT;
   localparam int ITEM_TARGET  = 1200;
   localparam int POOL_SIZE    = 22;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 80;

   localparam logic [REG_W-1:0]  STATUS_16     = REG_W'(PIX_TYPE_16);
   localparam logic [REG_W-1:0]  STATUS_32     = REG_W'(PIX_TYPE_32);
   localparam logic [REG_W-1:0]  SERRATE_FLAG  = REG_W'(1) << SERRATE_BIT;
   localparam logic [ADDR_W-1:0] DIRECTED_BASE = 23'h100000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTS} stall_style_type;

   // Every input of the block is given a known value at time zero.
   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   video_scanout_buffer_gate_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Predictor state. The registry arrays are only read below the fill
   // count, so their contents before the first write never matter.
   logic [ADDR_W-1:0]  noted_base  [SLOTS];
   logic [STAMP_W-1:0] noted_stamp [SLOTS];
   int unsigned        noted_count    = 0;
   logic [STAMP_W-1:0] blank_gen      = '0;
   logic               raw_blank_prev = 1'b0;
   logic [ADDR_W-1:0]  shown_addr     = '0;
   logic [REG_W-1:0]   shown_status   = '0;
   logic [FIELD_W-1:0] shown_stride   = '0;
   logic               shown_blank    = 1'b1;
   logic               first_field    = 1'b1;

   // Items still to send, and the scanout decisions still owed by the block.
   req_type pending_items[$];
   rsp_type scanout_expected[$];
   rsp_type frame_want;

   // Handshake bookkeeping shared between the clocked blocks.
   logic            req_taken     = 1'b0;
   int              quiet_cycles  = 0;
   int              mismatch_count = 0;
   int              gap_left      = 0;
   int              burst_left    = 0;
   int              stall_hold    = 0;
   stall_style_type stall_style   = STALL_NONE;
   logic            timed_out     = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   // Works out what the block must do with one accepted item. A note item
   // updates the registry and owes nothing; a frame item owes one result.
   task automatic predict_scanout(input req_type it);
      logic [1:0]  ptype;
      logic        serrate, raw_blank, blank, hit, found, wide;
      int unsigned stride, w, h, bpp, hs, he, vs, ve, k;
      logic [63:0] row, fb, num, den, hh, span;
      rsp_type     r;
      if (it.command == CMD_NOTE) begin
         // A null base is dropped, a known base is restamped, and a new base
         // only gets in while the registry has room.
         if (it.buffer_address != '0) begin
            found = 1'b0;
            for (k = 0; k < noted_count; k++) begin
               if (!found && noted_base[k] == it.buffer_address) begin
                  noted_stamp[k] = blank_gen;
                  found = 1'b1;
               end
            end
            if (!found && noted_count < SLOTS) begin
               noted_base[noted_count]  = it.buffer_address;
               noted_stamp[noted_count] = blank_gen;
               noted_count++;
            end
         end
      end else begin
         ptype     = it.vi_status[1:0];
         serrate   = it.vi_status[SERRATE_BIT];
         stride    = it.line_stride;
         raw_blank = (ptype < PIX_TYPE_16) || (it.line_stride == '0) ||
                     (it.vi_h_start == '0) || !it.game_started;
         w = stride;

         // Serrated modes halve the width when the horizontal window is
         // narrower than the stride over 1.875. A reversed window never halves.
         if (serrate && !raw_blank && it.vi_x_scale != '0) begin
            hs = it.vi_h_start[START_LSB +: SPAN_W];
            he = it.vi_h_start[SPAN_W-1:0];
            if (he >= hs &&
                (64'(he - hs) * it.vi_x_scale * WIDTH_RATIO_NUM) <
                (64'(stride) << WIDTH_RATIO_SHIFT))
               w = stride / 2;
         end
         wide = (ptype == PIX_TYPE_32);
         bpp  = wide ? 4 : 2;

         // The origin points one row in (two on an odd serrated field);
         // step back unless that would go below zero.
         row = 64'(w) * bpp * ((serrate && it.odd_line) ? 2 : 1);
         fb  = 64'(it.vi_origin);
         if (fb >= row)
            fb = fb - row;

         // Height from the vertical window with round-half-up division,
         // snapped to a multiple of four; out of range falls back to 3/4 width.
         h  = (w * 3) / 4;
         vs = it.vi_v_start[START_LSB +: SPAN_W];
         ve = it.vi_v_start[SPAN_W-1:0];
         if (ve > vs && it.vi_y_scale != '0 && w != 0) begin
            num = 64'(ve - vs) * it.vi_y_scale * it.line_stride;
            den = 64'(w) * 2048;
            hh  = (2 * num + den) / (2 * den) + 2;
            hh  = ((hh + 2) / 4) * 4;
            if (hh >= 4 && hh <= MAX_HEIGHT)
               h = 32'(hh);
         end

         // Only a rising raw blank opens a new generation.
         if (raw_blank && !raw_blank_prev)
            blank_gen = blank_gen + 1'b1;
         raw_blank_prev = raw_blank;

         // A frame is shown only when it lies inside a buffer noted in the
         // current generation.
         blank = raw_blank;
         if (!blank) begin
            span = 64'(w) * h * bpp;
            hit  = 1'b0;
            for (k = 0; k < noted_count; k++) begin
               if (fb >= 64'(noted_base[k]) && fb < 64'(noted_base[k]) + span &&
                   noted_stamp[k] == blank_gen)
                  hit = 1'b1;
            end
            blank = !hit;
         end
         if (blank) begin
            w = BLANK_WIDTH;
            h = BLANK_HEIGHT;
         end

         r.frame_address = fb[ADDR_W-1:0];
         r.frame_width   = FIELD_W'(w);
         r.frame_height  = FIELD_W'(h);
         r.pixel_size    = wide ? SIZE_32 : SIZE_16;
         r.blank         = blank;
         r.changed       = first_field || fb[ADDR_W-1:0] != shown_addr ||
                           it.vi_status != shown_status || it.line_stride != shown_stride ||
                           blank != shown_blank;
         first_field  = 1'b0;
         shown_addr   = fb[ADDR_W-1:0];
         shown_status = it.vi_status;
         shown_stride = it.line_stride;
         shown_blank  = blank;
         scanout_expected.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Stimulus builders. Spare register bits are always random, so every bit
   // of every field sees both values over the run.
   function automatic logic [REG_W-1:0] window_reg(input int unsigned start,
                                                   input int unsigned stop);
      logic [REG_W-1:0] v;
      v = $urandom;
      v[START_LSB +: SPAN_W] = SPAN_W'(start);
      v[SPAN_W-1:0]          = SPAN_W'(stop);
      return v;
   endfunction

   function automatic req_type frame_item(input logic [REG_W-1:0] status,
                                          input logic [ADDR_W-1:0] origin,
                                          input logic [FIELD_W-1:0] stride,
                                          input logic [REG_W-1:0] hreg,
                                          input logic [FIELD_W-1:0] xs,
                                          input logic [REG_W-1:0] vreg,
                                          input logic [FIELD_W-1:0] ys,
                                          input logic odd, input logic started);
      req_type it;
      it.command        = CMD_FRAME;
      it.buffer_address = ADDR_W'($urandom);
      it.vi_status      = status;
      it.vi_origin      = origin;
      it.line_stride    = stride;
      it.vi_h_start     = hreg;
      it.vi_x_scale     = xs;
      it.vi_v_start     = vreg;
      it.vi_y_scale     = ys;
      it.odd_line       = odd;
      it.game_started   = started;
      return it;
   endfunction

   function automatic req_type random_item();
      return frame_item($urandom, ADDR_W'($urandom), FIELD_W'($urandom), $urandom,
                        FIELD_W'($urandom), $urandom, FIELD_W'($urandom),
                        1'($urandom), 1'($urandom));
   endfunction

   function automatic req_type note_item(input logic [ADDR_W-1:0] addr);
      req_type it;
      it                = random_item();
      it.command        = CMD_NOTE;
      it.buffer_address = addr;
      return it;
   endfunction

   // A plausible frame whose scanout address lands inside the buffer at
   // target, with mostly sane windows and scales and a few wild ones.
   function automatic req_type aimed_frame(input logic [ADDR_W-1:0] target);
      int unsigned      pick, stride, bpp, hs, vs;
      logic [1:0]       ptype;
      logic [REG_W-1:0] status, hreg, vreg;
      logic [63:0]      origin;
      logic             odd;
      pick   = $urandom_range(0, 9);
      stride = (pick == 0) ? $urandom_range(1, 4095) :
               (pick < 3)  ? 640 :
               (pick < 5)  ? 320 : $urandom_range(16, 800);
      ptype  = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 1)) :
               ($urandom_range(0, 1) ? PIX_TYPE_32 : PIX_TYPE_16);
      status = $urandom;
      status[1:0] = ptype;
      odd    = 1'($urandom);
      bpp    = (ptype == PIX_TYPE_32) ? 4 : 2;
      hs     = $urandom_range(0, 300);
      vs     = $urandom_range(0, 100);
      hreg   = ($urandom_range(0, 7) == 0) ?
               window_reg($urandom_range(0, 1023), $urandom_range(0, 1023)) :
               window_reg(hs, hs + $urandom_range(100, 700));
      vreg   = ($urandom_range(0, 7) == 0) ?
               window_reg($urandom_range(0, 1023), $urandom_range(0, 1023)) :
               window_reg(vs, vs + $urandom_range(100, 500));
      origin = 64'(target) + 64'(stride) * bpp * ((status[SERRATE_BIT] && odd) ? 2 : 1) +
               $urandom_range(0, stride * bpp * 8);
      return frame_item(status, ADDR_W'(origin), FIELD_W'(stride), hreg,
                        ($urandom_range(0, 9) == 0) ? FIELD_W'($urandom) :
                                                      FIELD_W'($urandom_range(256, 1024)),
                        vreg,
                        ($urandom_range(0, 7) == 0) ? FIELD_W'($urandom) :
                                                      FIELD_W'($urandom_range(512, 2048)),
                        odd, $urandom_range(0, 19) != 0);
   endfunction

   // Stimulus. The directed part walks the corner cases in an order that
   // also steps the blank generation; the random part then plays fields:
   // usually a blank frame, a few notes, and frames aimed at those buffers.
   initial begin : stimulus
      logic [ADDR_W-1:0] base_pool [POOL_SIZE];
      logic [ADDR_W-1:0] last_base;
      req_type           field, prev_frame;
      int unsigned       pick;

      // Blank because the machine has not started; the first frame is
      // always changed, and the exact repeat right after it is not.
      field = frame_item(STATUS_32, DIRECTED_BASE + 23'd2660, 12'd640, window_reg(108, 748),
                         12'd1024, window_reg(37, 511), 12'd1024, 1'b0, 1'b0);
      pending_items.push_back(field);
      pending_items.push_back(field);
      // Null base, a new base, the same base again, and the address extremes.
      pending_items.push_back(note_item('0));
      pending_items.push_back(note_item(DIRECTED_BASE));
      pending_items.push_back(note_item(DIRECTED_BASE));
      pending_items.push_back(note_item(23'd1));
      pending_items.push_back(note_item('1));
      // Shown frame, 32-bit pixels, full width.
      pending_items.push_back(frame_item(STATUS_32, DIRECTED_BASE + 23'd2660, 12'd640,
                              window_reg(108, 748), 12'd1024, window_reg(37, 511),
                              12'd1024, 1'b0, 1'b1));
      // Serrated odd field with a narrow window, so the width is halved.
      pending_items.push_back(frame_item(STATUS_16 | SERRATE_FLAG, DIRECTED_BASE + 23'd1320,
                              12'd640, window_reg(108, 428), 12'd1024, window_reg(37, 511),
                              12'd1024, 1'b1, 1'b1));
      // Serrated with a reversed horizontal window: no halving.
      pending_items.push_back(frame_item(STATUS_16 | SERRATE_FLAG, DIRECTED_BASE + 23'd2600,
                              12'd640, window_reg(400, 100), 12'd1024, window_reg(37, 511),
                              12'd1024, 1'b1, 1'b1));
      // Serrated with a zero horizontal scale: no halving either.
      pending_items.push_back(frame_item(STATUS_16 | SERRATE_FLAG, DIRECTED_BASE + 23'd2600,
                              12'd640, window_reg(108, 428), 12'd0, window_reg(37, 511),
                              12'd1024, 1'b1, 1'b1));
      // Height over the limit, then an inverted vertical window.
      pending_items.push_back(frame_item(STATUS_32, DIRECTED_BASE + 23'd2660, 12'd640,
                              window_reg(108, 748), 12'd1024, window_reg(0, 1023),
                              12'd4095, 1'b0, 1'b1));
      pending_items.push_back(frame_item(STATUS_32, DIRECTED_BASE + 23'd2660, 12'd640,
                              window_reg(108, 748), 12'd1024, window_reg(300, 200),
                              12'd1024, 1'b0, 1'b1));
      // Zero stride opens a new generation, so the old note goes stale
      // until the base is noted again.
      pending_items.push_back(frame_item(STATUS_32, DIRECTED_BASE + 23'd2660, 12'd0,
                              window_reg(108, 748), 12'd1024, window_reg(37, 511),
                              12'd1024, 1'b0, 1'b1));
      field = frame_item(STATUS_32, DIRECTED_BASE + 23'd2660, 12'd640, window_reg(108, 748),
                         12'd1024, window_reg(37, 511), 12'd1024, 1'b0, 1'b1);
      pending_items.push_back(field);
      pending_items.push_back(note_item(DIRECTED_BASE));
      pending_items.push_back(field);
      // Horizontal register of zero, then every field at its extremes.
      pending_items.push_back(frame_item(STATUS_32, DIRECTED_BASE + 23'd2660, 12'd640, '0,
                              12'd1024, window_reg(37, 511), 12'd1024, 1'b0, 1'b1));
      pending_items.push_back(frame_item('1, '1, '1, '1, '1, '1, '1, 1'b1, 1'b1));
      pending_items.push_back(frame_item('0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0));
      // Pixel types below 16 bits blank the frame.
      pending_items.push_back(frame_item(REG_W'(0), DIRECTED_BASE + 23'd2660, 12'd640,
                              window_reg(108, 748), 12'd1024, window_reg(37, 511),
                              12'd1024, 1'b0, 1'b1));
      pending_items.push_back(frame_item(REG_W'(1), DIRECTED_BASE + 23'd2660, 12'd640,
                              window_reg(108, 748), 12'd1024, window_reg(37, 511),
                              12'd1024, 1'b0, 1'b1));
      // Origin smaller than one row: no step back.
      prev_frame = frame_item(STATUS_32, '0, 12'd640, window_reg(108, 748), 12'd1024,
                              window_reg(37, 511), 12'd1024, 1'b0, 1'b1);
      pending_items.push_back(prev_frame);

      // More bases than registry slots, so the registry fills for good and
      // later new bases are dropped.
      foreach (base_pool[i])
         base_pool[i] = ADDR_W'($urandom_range(1, 'h6FFFFF));
      last_base = base_pool[0];

      while (pending_items.size() < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            // Noise: null notes, stray notes and frames with random fields.
            if ($urandom_range(0, 1))
               pending_items.push_back(note_item(($urandom_range(0, 3) == 0) ? '0 :
                                       base_pool[$urandom_range(0, POOL_SIZE - 1)]));
            else
               pending_items.push_back(random_item());
         end else begin
            if ($urandom_range(0, 9) < 7) begin
               field = aimed_frame(last_base);
               case ($urandom_range(0, 3))
                  0:       field.game_started = 1'b0;
                  1:       field.vi_h_start   = '0;
                  2:       field.line_stride  = '0;
                  default: field.vi_status[1:0] = 2'($urandom_range(0, 1));
               endcase
               pending_items.push_back(field);
            end
            repeat ($urandom_range(1, 3)) begin
               last_base = base_pool[$urandom_range(0, POOL_SIZE - 1)];
               pending_items.push_back(note_item(last_base));
            end
            repeat ($urandom_range(1, 6)) begin
               pick = $urandom_range(0, 19);
               if (pick < 4) begin
                  // An exact repeat checks the unchanged case.
                  pending_items.push_back(prev_frame);
               end else begin
                  prev_frame = aimed_frame((pick < 16) ? last_base :
                                           base_pool[$urandom_range(0, POOL_SIZE - 1)]);
                  pending_items.push_back(prev_frame);
               end
            end
         end
      end
   end

   // Monitor: runs the predictor on each accepted item and checks each
   // accepted result against the oldest expectation. The block's outputs
   // are read here before its own updates for this edge land.
   always @(posedge clock) begin
      if (reset) begin
         req_taken    = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken)
            predict_scanout(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (scanout_expected.size() == 0) begin
               $error("result item arrived with no frame item waiting");
               mismatch_count++;
            end else begin
               frame_want = scanout_expected.pop_front();
               check_field("frame_address", 64'(frame_want.frame_address),
                           64'(rsp_payload.frame_address));
               check_field("frame_width", 64'(frame_want.frame_width),
                           64'(rsp_payload.frame_width));
               check_field("frame_height", 64'(frame_want.frame_height),
                           64'(rsp_payload.frame_height));
               check_field("pixel_size", 64'(frame_want.pixel_size),
                           64'(rsp_payload.pixel_size));
               check_field("blank", 64'(frame_want.blank), 64'(rsp_payload.blank));
               check_field("changed", 64'(frame_want.changed), 64'(rsp_payload.changed));
            end
         end
         if (req_taken || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   // Driver: on the falling edge, present the next item in bursts with
   // gaps of varying length, and hold an item steady until it is taken.
   // The receiver stall follows its own style, switched to a new random style
   // when its hold counter runs out, with some stretches that never stall at all.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left--;
            end else if (pending_items.size() > 0) begin
               req_payload <= pending_items.pop_front();
               req_valid   <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 20);
                  case ($urandom_range(0, 3))
                     0:       gap_left = 0;
                     1, 2:    gap_left = $urandom_range(1, 8);
                     default: gap_left = $urandom_range(20, 90);
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end

         if (stall_hold == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            stall_hold  = $urandom_range(50, 300);
         end else begin
            stall_hold--;
         end
         case (stall_style)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 4) != 0);
            default:     rsp_stall <= (stall_hold % 24) < 16;
         endcase
      end
   end

   // Run control: one reset at the start, then wait for the stimulus to
   // drain and every owed result to arrive. A long stretch with no item
   // moving on either channel ends the run as a hang.
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (!timed_out &&
             !(pending_items.size() == 0 && !req_valid && scanout_expected.size() == 0)) begin
         @(posedge clock);
         if (quiet_cycles >= QUIET_LIMIT)
            timed_out = 1'b1;
      end
      if (timed_out) begin
         $error("no item moved for %0d cycles", QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         // A note item may still be searching the registry after the last
         // result, and a stray extra result would show up in this window.
         repeat (DRAIN_CYCLES) @(negedge clock);
         if (scanout_expected.size() != 0) begin
            $error("%0d expected results never arrived", scanout_expected.size());
            mismatch_count++;
         end
         if (mismatch_count == 0)
            $display("Regression PASS");
         else
            $display("Regression FAIL");
         $finish;
      end
   end

endmodule

// ----- filelist.f -----
rtl/core/vsbg_pkg.sv
rtl/core/video_scanout_buffer_gate_core.sv
tb/tb_top.sv
